[rtl/mpsf_pkg.sv]
// Shared types, state/event/action codes and transition entry helpers for the provisioning FSM.
package mpsf_pkg;

    localparam int STATE_W  = 5;
    localparam int EVENT_W  = 5;
    localparam int ACTION_W = 5;

    typedef logic [STATE_W-1:0]  t_state;
    typedef logic [EVENT_W-1:0]  t_event;
    typedef logic [ACTION_W-1:0] t_action;

    // States
    localparam t_state ST_IDLE            = 5'd0;
    localparam t_state ST_WAIT_LINK       = 5'd1;
    localparam t_state ST_WAIT_INVITE     = 5'd2;
    localparam t_state ST_SEND_CAPS       = 5'd3;
    localparam t_state ST_WAIT_START      = 5'd4;
    localparam t_state ST_WAIT_PUB_KEY    = 5'd5;
    localparam t_state ST_GEN_PUB_KEY     = 5'd6;
    localparam t_state ST_VALID_PUB_KEY   = 5'd7;
    localparam t_state ST_SEND_PUB_KEY    = 5'd8;
    localparam t_state ST_PREP_OOB        = 5'd9;
    localparam t_state ST_WAIT_INPUT      = 5'd10;
    localparam t_state ST_SEND_INPUT_CPLT = 5'd11;
    localparam t_state ST_WAIT_CONF       = 5'd12;
    localparam t_state ST_CALC_CONF       = 5'd13;
    localparam t_state ST_SEND_CONF       = 5'd14;
    localparam t_state ST_WAIT_RANDOM     = 5'd15;
    localparam t_state ST_CHECK_CONF      = 5'd16;
    localparam t_state ST_CALC_SKEY       = 5'd17;
    localparam t_state ST_SEND_RANDOM     = 5'd18;
    localparam t_state ST_WAIT_DATA       = 5'd19;
    localparam t_state ST_DECRYPT_DATA    = 5'd20;
    localparam t_state ST_SEND_CPLT       = 5'd21;
    localparam t_state ST_LINK_FAILED     = 5'd22;

    // Events
    localparam t_event EV_BEGIN_NO_LINK      = 5'd0;
    localparam t_event EV_BEGIN_LINK_OPEN    = 5'd1;
    localparam t_event EV_LINK_OPENED        = 5'd2;
    localparam t_event EV_LINK_CLOSED_FAIL   = 5'd3;
    localparam t_event EV_LINK_CLOSED_OK     = 5'd4;
    localparam t_event EV_RECV_TIMEOUT       = 5'd5;
    localparam t_event EV_SEND_TIMEOUT       = 5'd6;
    localparam t_event EV_SENT_CAPS          = 5'd7;
    localparam t_event EV_SENT_PUB_KEY       = 5'd8;
    localparam t_event EV_SENT_INPUT_CPLT    = 5'd9;
    localparam t_event EV_SENT_CONF          = 5'd10;
    localparam t_event EV_SENT_RANDOM        = 5'd11;
    localparam t_event EV_SENT_COMPLETE      = 5'd12;
    localparam t_event EV_GOTO_INPUT         = 5'd13;
    localparam t_event EV_GOTO_CONF          = 5'd14;
    localparam t_event EV_INPUT_READY        = 5'd15;
    localparam t_event EV_CONF_READY         = 5'd16;
    localparam t_event EV_CONF_VERIFIED      = 5'd17;
    localparam t_event EV_CONF_FAILED        = 5'd18;
    localparam t_event EV_SKEY_READY         = 5'd19;
    localparam t_event EV_RECV_INVITE        = 5'd20;
    localparam t_event EV_RECV_START         = 5'd21;
    localparam t_event EV_RECV_PUB_KEY       = 5'd22;
    localparam t_event EV_PUB_KEY_VALID      = 5'd23;
    localparam t_event EV_PUB_KEY_INVALID    = 5'd24;
    localparam t_event EV_PUB_KEY_GENERATED  = 5'd25;
    localparam t_event EV_RECV_CONF          = 5'd26;
    localparam t_event EV_RECV_RANDOM        = 5'd27;
    localparam t_event EV_RECV_DATA          = 5'd28;
    localparam t_event EV_DATA_DECRYPTED     = 5'd29;
    localparam t_event EV_DATA_NOT_DECRYPTED = 5'd30;
    localparam t_event EV_RECV_BAD_PDU       = 5'd31;

    // Actions
    localparam t_action ACT_NONE                = 5'd0;
    localparam t_action ACT_LINK_CLOSED         = 5'd1;
    localparam t_action ACT_RECV_TIMEOUT        = 5'd2;
    localparam t_action ACT_SEND_TIMEOUT        = 5'd3;
    localparam t_action ACT_PROV_COMPLETE       = 5'd4;
    localparam t_action ACT_SETUP_NO_LINK       = 5'd5;
    localparam t_action ACT_OPEN_LINK           = 5'd6;
    localparam t_action ACT_SEND_CAPS           = 5'd7;
    localparam t_action ACT_WAIT_START          = 5'd8;
    localparam t_action ACT_RECV_START          = 5'd9;
    localparam t_action ACT_RECV_PUB_KEY        = 5'd10;
    localparam t_action ACT_VALIDATE_PUB_KEY    = 5'd11;
    localparam t_action ACT_SEND_PUB_KEY        = 5'd12;
    localparam t_action ACT_PREP_OOB            = 5'd13;
    localparam t_action ACT_WAIT_INPUT          = 5'd14;
    localparam t_action ACT_SEND_INPUT_CPLT     = 5'd15;
    localparam t_action ACT_WAIT_CONF           = 5'd16;
    localparam t_action ACT_SAVE_CONF           = 5'd17;
    localparam t_action ACT_CALC_CONF           = 5'd18;
    localparam t_action ACT_SEND_CONF           = 5'd19;
    localparam t_action ACT_WAIT_RANDOM         = 5'd20;
    localparam t_action ACT_CHECK_CONF          = 5'd21;
    localparam t_action ACT_CALC_SKEY           = 5'd22;
    localparam t_action ACT_SEND_RANDOM         = 5'd23;
    localparam t_action ACT_WAIT_DATA           = 5'd24;
    localparam t_action ACT_DECRYPT_DATA        = 5'd25;
    localparam t_action ACT_SEND_COMPLETE       = 5'd26;
    localparam t_action ACT_SEND_UNEXPECTED_PDU = 5'd27;
    localparam t_action ACT_PROTOCOL_ERROR      = 5'd28;

    // One table entry: hit, stay (no state change), next state, action
    typedef struct packed {
        logic    hit;
        logic    stay;
        t_state  next;
        t_action act;
    } t_entry;

    // Lookup result from the decoder to the top level
    typedef struct packed {
        logic    matched;
        logic    changed;
        t_action action;
        t_state  next_state;
    } t_lookup;

    localparam t_entry ENTRY_NONE = '{hit: 1'b0, stay: 1'b0, next: ST_IDLE, act: ACT_NONE};

    function automatic t_entry goto_entry(t_state nxt, t_action a);
        t_entry e;
        e = '{hit: 1'b1, stay: 1'b0, next: nxt, act: a};
        return e;
    endfunction

    function automatic t_entry stay_entry(t_action a);
        t_entry e;
        e = '{hit: 1'b1, stay: 1'b1, next: ST_IDLE, act: a};
        return e;
    endfunction

endpackage

[rtl/mpsf_decode.sv]
// Transition decode: per-state table first, common table second.
module mpsf_decode (
    input  mpsf_pkg::t_state  i_state,
    input  mpsf_pkg::t_event  i_event,
    output mpsf_pkg::t_lookup o_lookup
);

    mpsf_pkg::t_entry w_st;
    mpsf_pkg::t_entry w_cm;
    mpsf_pkg::t_entry w_sel;

    // Per-state table
    always_comb begin
        w_st = mpsf_pkg::ENTRY_NONE;
        case (i_state)
            mpsf_pkg::ST_IDLE: begin
                case (i_event)
                    mpsf_pkg::EV_BEGIN_NO_LINK:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_LINK,
                                                    mpsf_pkg::ACT_SETUP_NO_LINK);
                    mpsf_pkg::EV_BEGIN_LINK_OPEN:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_INVITE,
                                                    mpsf_pkg::ACT_OPEN_LINK);
                    mpsf_pkg::EV_LINK_CLOSED_FAIL:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_IDLE, mpsf_pkg::ACT_NONE);
                    mpsf_pkg::EV_LINK_CLOSED_OK:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_IDLE, mpsf_pkg::ACT_NONE);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_LINK: begin
                case (i_event)
                    mpsf_pkg::EV_BEGIN_LINK_OPEN:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_INVITE,
                                                    mpsf_pkg::ACT_OPEN_LINK);
                    mpsf_pkg::EV_LINK_OPENED:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_INVITE,
                                                    mpsf_pkg::ACT_OPEN_LINK);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_INVITE: begin
                case (i_event)
                    mpsf_pkg::EV_RECV_INVITE:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_SEND_CAPS,
                                                    mpsf_pkg::ACT_SEND_CAPS);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_SEND_CAPS: begin
                case (i_event)
                    mpsf_pkg::EV_SENT_CAPS:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_START,
                                                    mpsf_pkg::ACT_WAIT_START);
                    mpsf_pkg::EV_RECV_START:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_PUB_KEY,
                                                    mpsf_pkg::ACT_RECV_START);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_START: begin
                case (i_event)
                    mpsf_pkg::EV_RECV_START:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_PUB_KEY,
                                                    mpsf_pkg::ACT_RECV_START);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_PUB_KEY: begin
                case (i_event)
                    mpsf_pkg::EV_RECV_PUB_KEY:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_GEN_PUB_KEY,
                                                    mpsf_pkg::ACT_RECV_PUB_KEY);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_GEN_PUB_KEY: begin
                case (i_event)
                    mpsf_pkg::EV_PUB_KEY_GENERATED:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_VALID_PUB_KEY,
                                                    mpsf_pkg::ACT_VALIDATE_PUB_KEY);
                    mpsf_pkg::EV_RECV_CONF:
                        w_st = mpsf_pkg::stay_entry(mpsf_pkg::ACT_SAVE_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_VALID_PUB_KEY: begin
                case (i_event)
                    mpsf_pkg::EV_PUB_KEY_VALID:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_SEND_PUB_KEY,
                                                    mpsf_pkg::ACT_SEND_PUB_KEY);
                    mpsf_pkg::EV_RECV_CONF:
                        w_st = mpsf_pkg::stay_entry(mpsf_pkg::ACT_SAVE_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_SEND_PUB_KEY: begin
                case (i_event)
                    mpsf_pkg::EV_SENT_PUB_KEY:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_PREP_OOB,
                                                    mpsf_pkg::ACT_PREP_OOB);
                    mpsf_pkg::EV_RECV_CONF:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_CALC_CONF,
                                                    mpsf_pkg::ACT_CALC_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_PREP_OOB: begin
                case (i_event)
                    mpsf_pkg::EV_GOTO_INPUT:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_INPUT,
                                                    mpsf_pkg::ACT_WAIT_INPUT);
                    mpsf_pkg::EV_GOTO_CONF:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_CONF,
                                                    mpsf_pkg::ACT_WAIT_CONF);
                    mpsf_pkg::EV_RECV_CONF:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_CALC_CONF,
                                                    mpsf_pkg::ACT_CALC_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_INPUT: begin
                case (i_event)
                    mpsf_pkg::EV_INPUT_READY:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_SEND_INPUT_CPLT,
                                                    mpsf_pkg::ACT_SEND_INPUT_CPLT);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_SEND_INPUT_CPLT: begin
                case (i_event)
                    mpsf_pkg::EV_SENT_INPUT_CPLT:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_CONF,
                                                    mpsf_pkg::ACT_WAIT_CONF);
                    mpsf_pkg::EV_RECV_CONF:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_CALC_CONF,
                                                    mpsf_pkg::ACT_CALC_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_CONF: begin
                case (i_event)
                    mpsf_pkg::EV_RECV_CONF:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_CALC_CONF,
                                                    mpsf_pkg::ACT_CALC_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_CALC_CONF: begin
                case (i_event)
                    mpsf_pkg::EV_CONF_READY:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_SEND_CONF,
                                                    mpsf_pkg::ACT_SEND_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_SEND_CONF: begin
                case (i_event)
                    mpsf_pkg::EV_SENT_CONF:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_RANDOM,
                                                    mpsf_pkg::ACT_WAIT_RANDOM);
                    mpsf_pkg::EV_RECV_RANDOM:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_CHECK_CONF,
                                                    mpsf_pkg::ACT_CHECK_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_RANDOM: begin
                case (i_event)
                    mpsf_pkg::EV_RECV_RANDOM:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_CHECK_CONF,
                                                    mpsf_pkg::ACT_CHECK_CONF);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_CHECK_CONF: begin
                case (i_event)
                    mpsf_pkg::EV_CONF_VERIFIED:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_CALC_SKEY,
                                                    mpsf_pkg::ACT_CALC_SKEY);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_CALC_SKEY: begin
                case (i_event)
                    mpsf_pkg::EV_SKEY_READY:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_SEND_RANDOM,
                                                    mpsf_pkg::ACT_SEND_RANDOM);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_SEND_RANDOM: begin
                case (i_event)
                    mpsf_pkg::EV_SENT_RANDOM:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_WAIT_DATA,
                                                    mpsf_pkg::ACT_WAIT_DATA);
                    mpsf_pkg::EV_RECV_DATA:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_DECRYPT_DATA,
                                                    mpsf_pkg::ACT_DECRYPT_DATA);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_WAIT_DATA: begin
                case (i_event)
                    mpsf_pkg::EV_RECV_DATA:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_DECRYPT_DATA,
                                                    mpsf_pkg::ACT_DECRYPT_DATA);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_DECRYPT_DATA: begin
                case (i_event)
                    mpsf_pkg::EV_DATA_DECRYPTED:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_SEND_CPLT,
                                                    mpsf_pkg::ACT_SEND_COMPLETE);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_SEND_CPLT: begin
                case (i_event)
                    mpsf_pkg::EV_SENT_COMPLETE,
                    mpsf_pkg::EV_LINK_CLOSED_OK,
                    mpsf_pkg::EV_SEND_TIMEOUT:
                        w_st = mpsf_pkg::goto_entry(mpsf_pkg::ST_IDLE,
                                                    mpsf_pkg::ACT_PROV_COMPLETE);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            mpsf_pkg::ST_LINK_FAILED: begin
                // Absorb further protocol traffic without leaving the failed state
                case (i_event)
                    mpsf_pkg::EV_RECV_BAD_PDU,
                    mpsf_pkg::EV_RECV_INVITE,
                    mpsf_pkg::EV_RECV_START,
                    mpsf_pkg::EV_RECV_PUB_KEY,
                    mpsf_pkg::EV_RECV_CONF,
                    mpsf_pkg::EV_RECV_RANDOM,
                    mpsf_pkg::EV_RECV_DATA,
                    mpsf_pkg::EV_PUB_KEY_INVALID,
                    mpsf_pkg::EV_CONF_FAILED,
                    mpsf_pkg::EV_DATA_NOT_DECRYPTED:
                        w_st = mpsf_pkg::stay_entry(mpsf_pkg::ACT_SEND_UNEXPECTED_PDU);
                    default: w_st = mpsf_pkg::ENTRY_NONE;
                endcase
            end
            default: w_st = mpsf_pkg::ENTRY_NONE;
        endcase
    end

    // Common table, shared by all states
    always_comb begin
        case (i_event)
            mpsf_pkg::EV_LINK_CLOSED_FAIL,
            mpsf_pkg::EV_LINK_CLOSED_OK:
                w_cm = mpsf_pkg::goto_entry(mpsf_pkg::ST_IDLE, mpsf_pkg::ACT_LINK_CLOSED);
            mpsf_pkg::EV_RECV_TIMEOUT:
                w_cm = mpsf_pkg::goto_entry(mpsf_pkg::ST_IDLE, mpsf_pkg::ACT_RECV_TIMEOUT);
            mpsf_pkg::EV_SEND_TIMEOUT:
                w_cm = mpsf_pkg::goto_entry(mpsf_pkg::ST_IDLE, mpsf_pkg::ACT_SEND_TIMEOUT);
            mpsf_pkg::EV_RECV_BAD_PDU,
            mpsf_pkg::EV_RECV_INVITE,
            mpsf_pkg::EV_RECV_START,
            mpsf_pkg::EV_RECV_PUB_KEY,
            mpsf_pkg::EV_RECV_CONF,
            mpsf_pkg::EV_RECV_RANDOM,
            mpsf_pkg::EV_RECV_DATA,
            mpsf_pkg::EV_PUB_KEY_INVALID,
            mpsf_pkg::EV_CONF_FAILED,
            mpsf_pkg::EV_DATA_NOT_DECRYPTED:
                w_cm = mpsf_pkg::goto_entry(mpsf_pkg::ST_LINK_FAILED,
                                            mpsf_pkg::ACT_PROTOCOL_ERROR);
            default: w_cm = mpsf_pkg::ENTRY_NONE;
        endcase
    end

    // State table wins over the common table
    assign w_sel = w_st.hit ? w_st : w_cm;

    assign o_lookup.matched    = w_sel.hit;
    assign o_lookup.action     = w_sel.act;
    assign o_lookup.changed    = w_sel.hit & ~w_sel.stay;
    assign o_lookup.next_state = (w_sel.hit & ~w_sel.stay) ? w_sel.next : i_state;

endmodule

[rtl/mesh_provisioning_server_fsm.sv]
// Top level of the provisioning server state machine: input word register, state, result register.
// Each event word is captured in an input register, resolved against the
// current state by a combinational table decode, and the result word and the new state are
// loaded together. A new word is accepted every cycle while the result side
// keeps taking words; the state register feeding the decode is what sets this rate.
// A word passes the input register, then the result register. Reset puts the state at idle.
module mesh_provisioning_server_fsm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  mpsf_pkg::t_event        i_event_code,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_matched,
    output mpsf_pkg::t_action       o_action_code,
    output logic                    o_state_changed,
    output mpsf_pkg::t_state        o_new_state
);

    logic               r_in_valid;
    mpsf_pkg::t_event   r_event;
    mpsf_pkg::t_state   r_state;
    logic               r_out_valid;
    logic               r_matched;
    mpsf_pkg::t_action  r_action;
    logic               r_changed;
    mpsf_pkg::t_state   r_new_state;

    mpsf_pkg::t_lookup  w_lookup;
    mpsf_pkg::t_state   n_state;
    logic               w_out_free;
    logic               w_adv;
    logic               w_in_acc;

    mpsf_decode u_decode (
        .i_state  (r_state),
        .i_event  (r_event),
        .o_lookup (w_lookup)
    );

    assign w_out_free = ~r_out_valid | i_out_ready;
    assign w_adv      = r_in_valid & w_out_free;
    assign o_in_ready = ~r_in_valid | w_out_free;
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign n_state    = w_adv ? w_lookup.next_state : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= mpsf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_event <= i_event_code;
        end
        if (w_adv) begin
            r_matched   <= w_lookup.matched;
            r_action    <= w_lookup.action;
            r_changed   <= w_lookup.changed;
            r_new_state <= w_lookup.next_state;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_matched       = r_matched;
    assign o_action_code   = r_action;
    assign o_state_changed = r_changed;
    assign o_new_state     = r_new_state;

    // The shown result always reflects the state the machine is in now
    a_state_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == r_new_state))
        else $error("state register disagrees with reported new state");

    a_nomatch_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_matched) |-> (r_action == mpsf_pkg::ACT_NONE && !r_changed))
        else $error("unmatched event reported an action or state change");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= mpsf_pkg::ST_LINK_FAILED)
        else $error("state register out of range");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("state moved without a word being resolved");

endmodule
